// ===== src/lkvc_pkg.sv =====
`default_nettype none
package lkvc_pkg;

  localparam int ENTRIES   = 16;
  localparam int KEY_W     = 32;
  localparam int VALUE_W   = 32;
  localparam int CAP_W     = 5;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [CAP_W-1:0]   CAP_RESET  = CAP_W'(16);
  localparam logic [VALUE_W-1:0] MISS_VALUE = '1;
  localparam logic [VALUE_W-1:0] PUT_VALUE  = '0;

  typedef enum logic {
    REQ_GET = 1'b0,
    REQ_PUT = 1'b1
  } req_t;

  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_NONE     = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic update;
    logic hit;
    logic fill;
  } mode_t;

  typedef struct packed {
    logic               pass;
    logic               found;
    logic [VALUE_W-1:0] found_value;
  } chain_t;

endpackage
`default_nettype wire

// ===== src/lru_key_value_cache.sv =====
// Fully associative key/value cache with least-recently-used replacement.
// Request channel: in_valid / in_stall with req_type, lookup_key and
// write_value. A get returns the stored value with hit set, or all ones with
// hit clear; a put writes the value (update or insert) and returns zero, with
// hit telling whether the key was already present.
// Result channel: out_valid / out_stall with hit and read_value, one result
// per request, in request order.
// The result is registered at the edge that accepts the request. One
// request per cycle is taken while the result register is free or being
// drained; the whole update is one pass down the cell row.
// The entries sit in a row of 16 cells ordered by recency, cell 0 being the
// most recent; an update shifts cells down by one up to the hit, free or
// victim cell and loads the request at cell 0.
// While out_stall holds a waiting result, in_stall is raised and the result
// is held. Reset empties the cache and sets capacity_in_use to 16; the APB
// register at address 0 sets how many entries are held before evicting.
`default_nettype none
module lru_key_value_cache import lkvc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [DATA_W-1:0]   pwdata,
  output logic      [DATA_W-1:0]   prdata,
  output logic                     pready,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                req_type,
  input  wire logic signed [KEY_W-1:0]   lookup_key,
  input  wire logic signed [VALUE_W-1:0] write_value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     hit,
  output logic signed [VALUE_W-1:0] read_value
);

  logic [CAP_W-1:0] capacity_in_use;
  logic [CNT_W-1:0] entries_used;
  logic             accept;
  logic             is_put;
  logic             free;
  logic [CMP_W-1:0] used_x;
  logic [CMP_W-1:0] cap_x;
  logic [KEY_W-1:0] key_u;
  entry_t           new_entry;
  mode_t            mode;
  entry_t           entries [ENTRIES];
  chain_t           chain [ENTRIES+1];
  logic [ENTRIES-1:0] valid_vec;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
      capacity_in_use <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_CAPACITY) begin
      prdata = DATA_W'(capacity_in_use);
    end else begin
      prdata = '0;
    end
  end

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_put   = (req_type == REQ_PUT);
  assign key_u    = lookup_key;
  assign used_x   = CMP_W'(entries_used);
  assign cap_x    = CMP_W'(capacity_in_use);

  assign chain[0] = '{pass: 1'b1, found: 1'b0, found_value: '0};

  always_comb begin
    free = (used_x < cap_x || used_x == '0) && used_x < CMP_W'(ENTRIES);
    mode.hit    = chain[ENTRIES].found;
    mode.fill   = !chain[ENTRIES].found && free;
    mode.update = accept && (is_put || chain[ENTRIES].found);
    new_entry.valid = 1'b1;
    new_entry.key   = key_u;
    new_entry.value = is_put ? write_value : chain[ENTRIES].found_value;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    entry_t prev_i;
    logic   next_valid_i;
    if (i == 0) begin : g_head
      assign prev_i = new_entry;
    end else begin : g_body
      assign prev_i = entries[i-1];
    end
    if (i == ENTRIES - 1) begin : g_tail
      assign next_valid_i = 1'b0;
    end else begin : g_inner
      assign next_valid_i = entries[i+1].valid;
    end
    lkvc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .prev       (prev_i),
      .next_valid (next_valid_i),
      .lookup_key (key_u),
      .mode       (mode),
      .chain_in   (chain[i]),
      .chain_out  (chain[i+1]),
      .entry      (entries[i])
    );
    assign valid_vec[i] = entries[i].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_used <= '0;
    end else if (mode.update && is_put && mode.fill) begin
      entries_used <= entries_used + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit <= chain[ENTRIES].found;
      if (is_put) begin
        read_value <= PUT_VALUE;
      end else if (chain[ENTRIES].found) begin
        read_value <= chain[ENTRIES].found_value;
      end else begin
        read_value <= MISS_VALUE;
      end
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(entries_used) <= CMP_W'(ENTRIES))
    else $error("entry count beyond the cell row");

  a_used_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(entries_used))
    else $error("entry count disagrees with valid cells");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted request gave no result");

  a_put_result_zero: assert property (@(posedge clk) disable iff (rst)
    accept && is_put |=> read_value == PUT_VALUE)
    else $error("put result not zero");

endmodule
`default_nettype wire

// ===== src/lkvc_cell.sv =====
`default_nettype none
module lkvc_cell import lkvc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire entry_t           prev,
  input  wire logic             next_valid,
  input  wire logic [KEY_W-1:0] lookup_key,
  input  wire mode_t            mode,
  input  wire chain_t           chain_in,
  output chain_t                chain_out,
  output entry_t                entry
);

  logic match;
  logic stop;
  logic load;

  always_comb begin
    match = entry.valid && (entry.key == lookup_key);
    if (mode.hit) begin
      stop = match;
    end else if (mode.fill) begin
      stop = !entry.valid;
    end else begin
      stop = entry.valid && !next_valid;
    end
    load = mode.update && chain_in.pass;
    chain_out.pass        = chain_in.pass && !stop;
    chain_out.found       = chain_in.found || match;
    chain_out.found_value = match ? entry.value : chain_in.found_value;
  end

  // shift the neighbor's entry in
  always_ff @(posedge clk) begin
    if (load) begin
      entry.key   <= prev.key;
      entry.value <= prev.value;
    end
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (load) begin
      entry.valid <= prev.valid;
    end
  end

endmodule
`default_nettype wire

// ===== test/lru_key_value_cache_tb.sv =====
`timescale 1ns / 100ps
module lru_key_value_cache_tb import lkvc_pkg::*;;

  localparam logic [ADDR_W-1:0] CAP_ADDR = ADDR_W'(4 * int'(REG_CAPACITY));
  localparam int ITEMS_PER_SEG = 156;
  localparam int POOL_SIZE = 24;

  typedef struct {
    logic               hit;
    logic [VALUE_W-1:0] value;
  } reply_t;

  class lru_mirror;
    logic [CAP_W-1:0]   capacity;
    logic [KEY_W-1:0]   keys[ENTRIES];
    logic [VALUE_W-1:0] values[ENTRIES];
    bit                 live[ENTRIES];
    int unsigned        age[ENTRIES];
    int unsigned        used;
    reply_t             pending[$];
    int unsigned        mismatches;

    function new();
      capacity = CAP_RESET;
      used = 0;
      mismatches = 0;
      foreach (live[i]) begin
        live[i] = 1'b0;
        age[i] = 0;
      end
    endfunction

    function int unsigned effective_capacity();
      if (capacity == 0) return 1;
      if (capacity > ENTRIES) return ENTRIES;
      return capacity;
    endfunction

    function void set_capacity(logic [DATA_W-1:0] word);
      capacity = word[CAP_W-1:0];
    endfunction

    function int unsigned pending_count();
      return pending.size();
    endfunction

    // make entry e the most recent
    function void promote(int e);
      foreach (live[i]) begin
        if (live[i] && i != e && age[i] < age[e]) age[i]++;
      end
      age[e] = 0;
    endfunction

    function void note_request(req_t kind, logic [KEY_W-1:0] key,
                               logic [VALUE_W-1:0] data);
      reply_t r;
      int     found;
      int     slot;
      int     victim;
      found = -1;
      foreach (live[i]) begin
        if (found < 0 && live[i] && keys[i] == key) found = i;
      end
      r.hit = (found >= 0);
      if (kind == REQ_GET) begin
        r.value = MISS_VALUE;
        if (found >= 0) begin
          r.value = values[found];
          promote(found);
        end
      end else begin
        r.value = PUT_VALUE;
        if (found >= 0) begin
          values[found] = data;
          promote(found);
        end else if (used < effective_capacity()) begin
          slot = -1;
          foreach (live[i]) begin
            if (live[i]) age[i]++;
            else if (slot < 0) slot = i;
          end
          live[slot] = 1'b1;
          keys[slot] = key;
          values[slot] = data;
          age[slot] = 0;
          used++;
        end else begin
          victim = -1;
          foreach (live[i]) begin
            if (live[i] && (victim < 0 || age[i] > age[victim])) victim = i;
          end
          keys[victim] = key;
          values[victim] = data;
          promote(victim);
        end
      end
      pending.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h, expected %h", what, got, want);
      mismatches++;
    endtask

    task check_reply(logic got_hit, logic [VALUE_W-1:0] got_value);
      reply_t r;
      if (pending.size() == 0) begin
        report_mismatch("result with no request", got_value, 'x);
      end else begin
        r = pending.pop_front();
        if (got_hit !== r.hit) report_mismatch("hit", got_hit, r.hit);
        if (got_value !== r.value) report_mismatch("read_value", got_value, r.value);
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                req_type = 1'b0;
  logic [KEY_W-1:0]    lookup_key = '0;
  logic [VALUE_W-1:0]  write_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                hit;
  logic [VALUE_W-1:0]  read_value;

  int                  send_idle_pct = 0;
  int                  stall_pct = 0;
  logic [KEY_W-1:0]    key_pool[POOL_SIZE];
  logic [CAP_W-1:0]    seg_cap[8] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd16, 5'd2, 5'd9};

  lru_mirror mirror = new();

  lru_key_value_cache u_top (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .lookup_key(lookup_key),
    .write_value(write_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hit(hit),
    .read_value(read_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAIL lru_key_value_cache");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        mirror.note_request(req_t'(req_type), lookup_key, write_value);
      end
      if (out_valid && !out_stall) mirror.check_reply(hit, read_value);
    end
  end

  task automatic send_request(req_t kind, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    lookup_key <= key;
    write_value <= data;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off requests until every result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (mirror.pending_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    logic [DATA_W-1:0] word;
    word = $urandom;
    word[CAP_W-1:0] = cap;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAP_ADDR;
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    mirror.set_capacity(word);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[CAP_W-1:0] !== cap) mirror.report_mismatch("capacity readback", prdata, cap);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    req_t               kind;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] data;
    int                 span;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_request(REQ_GET, 32'h0000_0000, 32'h5A5A_5A5A);
    send_request(REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_PUT, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(REQ_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
    send_request(REQ_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_GET, 32'h0000_0001, 32'h0000_0000);
    for (int i = 0; i < 12; i++) send_request(REQ_PUT, 32'h100 + i, ~i);
    send_request(REQ_PUT, 32'h0000_0200, 32'hCAFE_F00D);
    send_request(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_GET, 32'h8000_0000, 32'h0000_0000);

    for (int seg = 0; seg < 8; seg++) begin
      wait_idle();
      if (seg != 0) write_capacity(seg_cap[seg]);
      case (seg % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 68;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 68;
        end
        default: begin
          send_idle_pct = 35;
          stall_pct = 35;
        end
      endcase
      span = mirror.effective_capacity() + 4;
      if (span > POOL_SIZE) span = POOL_SIZE;
      repeat (ITEMS_PER_SEG) begin
        kind = $urandom_range(1) ? REQ_PUT : REQ_GET;
        if ($urandom_range(9) == 0) key = $urandom;
        else key = key_pool[$urandom_range(span - 1)];
        case ($urandom_range(15))
          0: data = 32'h8000_0000;
          1: data = 32'h7FFF_FFFF;
          2: data = 32'hFFFF_FFFF;
          3: data = 32'h0000_0000;
          default: data = $urandom;
        endcase
        send_request(kind, key, data);
      end
    end
    wait_idle();

    if (mirror.mismatches == 0) begin
      $display("PASS lru_key_value_cache");
    end else begin
      $display("FAIL lru_key_value_cache");
    end
    $finish;
  end

endmodule
